[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds at an edge, cons must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// When ante holds at an edge, cons must hold at the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/crsd_pkg.sv]
// ----------------------------------------------------------------------------
// crsd_pkg
// Types, constants and helpers shared by the sprite decoder modules.
// ----------------------------------------------------------------------------
package crsd_pkg;

	localparam int unsigned ScreenWidthDef  = 256;
	localparam int unsigned ScreenHeightDef = 192;
	localparam int unsigned QueueDepthDef   = 4;
	localparam int unsigned HeaderBytes     = 6;
	localparam int unsigned CfgIdxW         = 3;
	localparam int unsigned CfgDataW        = 9;
	localparam logic [5:0]  CountMask       = 6'h3F;

	typedef enum logic [2:0] {
		CFG_CLIP_LEFT,
		CFG_CLIP_TOP,
		CFG_CLIP_RIGHT_EXCL,
		CFG_CLIP_BOTTOM_EXCL,
		CFG_ROW_PITCH
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_CODE,
		PH_LITERAL,
		PH_FILL,
		PH_SKIP_LEN,
		PH_MOVE_LEN,
		PH_MOVE_X
	} phase_t;

	typedef enum logic [1:0] {
		OP_LITERAL,
		OP_FILL,
		OP_SKIP,
		OP_MOVE
	} op_t;

	typedef enum logic [1:0] {
		WALK_IDLE,
		WALK_RUN,
		WALK_FLUSH
	} walk_t;

	typedef struct packed {
		logic [7:0] clip_left;
		logic [7:0] clip_top;
		logic [8:0] clip_right_excl;
		logic [8:0] clip_bottom_excl;
		logic [8:0] row_pitch;
	} clip_cfg_t;

	// One unit of work for the back end: a horizontal run of equal-valued
	// pixels on one row, or the end-of-sprite marker.
	typedef struct packed {
		logic        is_done;
		logic        flip;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  value;
		logic [5:0]  count;
	} draw_cmd_t;

	// Horizontal cursor step: leftwards when the sprite is mirrored.
	function automatic logic [15:0] step_x(input logic [15:0] x, input logic [15:0] d,
		input logic flip);
		return flip ? (x - d) : (x + d);
	endfunction

endpackage

[rtl/core/crsd_stream_if.sv]
// ----------------------------------------------------------------------------
// crsd stream interfaces
// Valid/ready channels for sprite bytes in and pixel writes out.
// ----------------------------------------------------------------------------
interface crsd_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         sprite_byte;
	logic               sprite_start;
	logic signed [11:0] origin_x;
	logic signed [11:0] origin_y;
	logic               mirror;

	modport source(output valid, sprite_byte, sprite_start, origin_x, origin_y, mirror,
		input ready);
	modport sink(input valid, sprite_byte, sprite_start, origin_x, origin_y, mirror,
		output ready);
endinterface

interface crsd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_address;
	logic [7:0]  pixel_value;
	logic        write_valid;
	logic        sprite_done;
	logic        last_of_run;

	modport source(output valid, pixel_address, pixel_value, write_valid, sprite_done,
		last_of_run, input ready);
	modport sink(input valid, pixel_address, pixel_value, write_valid, sprite_done,
		last_of_run, output ready);
endinterface

[rtl/core/crsd_cmd_queue.sv]
// ----------------------------------------------------------------------------
// crsd_cmd_queue
// Small register FIFO of draw commands between the decode front and the
// pixel back end.
// ----------------------------------------------------------------------------
module crsd_cmd_queue import crsd_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  draw_cmd_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output draw_cmd_t head
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	draw_cmd_t       slots_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (fill_q == FullCnt);
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/crsd_front.sv]
// ----------------------------------------------------------------------------
// crsd_front
// Byte-level decoder: parses the header, tracks the cursor and turns code
// bytes into draw commands for the back end.
// ----------------------------------------------------------------------------
module crsd_front import crsd_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	crsd_in_if.sink        sprite,
	input  clip_cfg_t      cfg,
	output logic           cmd_push,
	output draw_cmd_t      cmd_data,
	input  logic           cmd_full
);

	localparam logic [2:0] LastHeaderIdx = 3'(HeaderBytes - 1);

	phase_t      phase_q;
	logic [2:0]  header_index_q;
	logic [7:0]  header_lo_q;
	logic [5:0]  literal_left_q;
	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [15:0] row_start_x_q;
	logic [5:0]  run_count_q;
	logic        flip_q;
	logic        rejected_q;

	// State as seen by the current byte, after a possible sprite start.
	phase_t      e_phase;
	logic [2:0]  e_hidx;
	logic [7:0]  e_hlo;
	logic [5:0]  e_lit;
	logic [15:0] e_cx;
	logic [15:0] e_cy;
	logic [15:0] e_rsx;
	logic [5:0]  e_run;
	logic        e_flip;
	logic        e_rej;

	phase_t      n_phase;
	logic [2:0]  n_hidx;
	logic [7:0]  n_hlo;
	logic [5:0]  n_lit;
	logic [15:0] n_cx;
	logic [15:0] n_cy;
	logic [15:0] n_rsx;
	logic [5:0]  n_run;
	logic        n_rej;

	logic        accept;
	logic        want_push;
	logic [7:0]  b;
	logic [5:0]  cnt;
	logic [15:0] span;
	logic signed [17:0] lo_edge;
	logic signed [17:0] hi_edge;
	logic        x_out;
	logic        y_out;

	assign sprite.ready = !cmd_full;
	assign accept       = sprite.valid && sprite.ready;
	assign cmd_push     = accept && want_push;
	assign b            = sprite.sprite_byte;
	assign cnt          = b[5:0] & CountMask;

	always_comb begin
		if (sprite.sprite_start) begin
			e_phase = PH_HEADER;
			e_hidx  = '0;
			e_hlo   = '0;
			e_lit   = '0;
			e_run   = '0;
			e_cx    = {{4{sprite.origin_x[11]}}, sprite.origin_x};
			e_cy    = {{4{sprite.origin_y[11]}}, sprite.origin_y};
			e_rsx   = {{4{sprite.origin_x[11]}}, sprite.origin_x};
			e_flip  = sprite.mirror;
			e_rej   = 1'b0;
		end else begin
			e_phase = phase_q;
			e_hidx  = header_index_q;
			e_hlo   = header_lo_q;
			e_lit   = literal_left_q;
			e_run   = run_count_q;
			e_cx    = cursor_x_q;
			e_cy    = cursor_y_q;
			e_rsx   = row_start_x_q;
			e_flip  = flip_q;
			e_rej   = rejected_q;
		end
	end

	// Extent of the sprite along the axis that the current header word closes.
	always_comb begin
		span    = {b, e_hlo};
		lo_edge = (e_hidx == 3'd3) ? $signed({{2{e_cx[15]}}, e_cx})
		                           : $signed({{2{e_cy[15]}}, e_cy});
		hi_edge = lo_edge + $signed({2'b00, span}) - 18'sd1;
		x_out   = (lo_edge >= $signed({9'b0, cfg.clip_right_excl}))
		       || (hi_edge < $signed({10'b0, cfg.clip_left}));
		y_out   = (lo_edge >= $signed({9'b0, cfg.clip_bottom_excl}))
		       || (hi_edge < $signed({10'b0, cfg.clip_top}));
	end

	// Next decode phase.
	always_comb begin
		n_phase = e_phase;
		unique case (e_phase)
			PH_IDLE: begin
				n_phase = PH_IDLE;
			end
			PH_HEADER: begin
				if (e_hidx == LastHeaderIdx) begin
					n_phase = PH_CODE;
				end
			end
			PH_CODE: begin
				unique case (op_t'(b[7:6]))
					OP_LITERAL: if (cnt != '0) n_phase = PH_LITERAL;
					OP_FILL:    n_phase = PH_FILL;
					OP_SKIP:    if (cnt == '0) n_phase = PH_SKIP_LEN;
					OP_MOVE:    n_phase = (cnt != '0) ? PH_MOVE_X : PH_MOVE_LEN;
					default:    n_phase = e_phase;
				endcase
			end
			PH_LITERAL: begin
				if (e_lit == 6'd1) begin
					n_phase = PH_CODE;
				end
			end
			PH_FILL, PH_SKIP_LEN, PH_MOVE_X: begin
				n_phase = PH_CODE;
			end
			PH_MOVE_LEN: begin
				n_phase = (b == 8'h00) ? PH_IDLE : PH_MOVE_X;
			end
			default: n_phase = PH_IDLE;
		endcase
	end

	// Cursor, counters and command output.
	always_comb begin
		n_hidx    = e_hidx;
		n_hlo     = e_hlo;
		n_lit     = e_lit;
		n_cx      = e_cx;
		n_cy      = e_cy;
		n_rsx     = e_rsx;
		n_run     = e_run;
		n_rej     = e_rej;
		want_push = 1'b0;
		cmd_data  = '{is_done: 1'b0, flip: e_flip, x: e_cx, y: e_cy, value: b,
		              count: 6'd1};
		unique case (e_phase)
			PH_HEADER: begin
				n_hidx = e_hidx + 3'd1;
				if (e_hidx == 3'd2 || e_hidx == 3'd4) begin
					n_hlo = b;
				end else if (e_hidx == 3'd3) begin
					if (x_out) n_rej = 1'b1;
					if (e_flip) n_cx = hi_edge[15:0];
					n_rsx = e_flip ? hi_edge[15:0] : e_cx;
				end else if (e_hidx == 3'd5) begin
					if (y_out) n_rej = 1'b1;
				end
			end
			PH_CODE: begin
				unique case (op_t'(b[7:6]))
					OP_LITERAL: if (cnt != '0) n_lit = cnt;
					OP_FILL:    n_run = cnt;
					OP_SKIP:    if (cnt != '0) n_cx = step_x(e_cx, {10'b0, cnt}, e_flip);
					OP_MOVE:    if (cnt != '0) n_cy = e_cy + {10'b0, cnt};
					default:    n_run = e_run;
				endcase
			end
			PH_LITERAL: begin
				want_push = !e_rej;
				n_cx      = step_x(e_cx, 16'd1, e_flip);
				n_lit     = e_lit - 6'd1;
			end
			PH_FILL: begin
				want_push      = !e_rej && (e_run != '0);
				cmd_data.count = e_run;
				n_cx           = step_x(e_cx, {10'b0, e_run}, e_flip);
				n_run          = '0;
			end
			PH_SKIP_LEN: begin
				n_cx = step_x(e_cx, {8'b0, b}, e_flip);
			end
			PH_MOVE_LEN: begin
				if (b == 8'h00) begin
					want_push        = 1'b1;
					cmd_data.is_done = 1'b1;
				end else begin
					n_cy = e_cy + {8'b0, b};
				end
			end
			PH_MOVE_X: begin
				n_cx = step_x(e_rsx, {8'b0, b}, e_flip);
			end
			default: n_hidx = e_hidx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			header_index_q <= '0;
			header_lo_q    <= '0;
			literal_left_q <= '0;
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			row_start_x_q  <= '0;
			run_count_q    <= '0;
			flip_q         <= 1'b0;
			rejected_q     <= 1'b0;
		end else if (accept) begin
			phase_q        <= n_phase;
			header_index_q <= n_hidx;
			header_lo_q    <= n_hlo;
			literal_left_q <= n_lit;
			cursor_x_q     <= n_cx;
			cursor_y_q     <= n_cy;
			row_start_x_q  <= n_rsx;
			run_count_q    <= n_run;
			flip_q         <= e_flip;
			rejected_q     <= n_rej;
		end
	end

endmodule

[rtl/core/crsd_back.sv]
// ----------------------------------------------------------------------------
// crsd_back
// Pixel walker: expands draw commands one pixel per cycle while the output
// accepts, clips each pixel to the window and forms its frame buffer address.
// ----------------------------------------------------------------------------
module crsd_back import crsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  clip_cfg_t  cfg,
	input  logic       cmd_empty,
	input  draw_cmd_t  cmd_head,
	output logic       cmd_pop,
	crsd_out_if.source pixel
);

	walk_t       walk_q;
	walk_t       walk_n;
	logic [15:0] cur_x_q;
	logic [15:0] cur_y_q;
	logic [7:0]  val_q;
	logic [5:0]  left_q;
	logic        flip_q;

	// One visible pixel is held back until the next one is found, so that
	// the final pixel of a command can carry last_of_run.
	logic        pend_v_q;
	logic [15:0] pend_addr_q;
	logic [7:0]  pend_val_q;

	logic        out_v_q;
	logic [15:0] out_addr_q;
	logic [7:0]  out_val_q;
	logic        out_wv_q;
	logic        out_done_q;
	logic        out_last_q;

	logic        out_free;
	logic        visible;
	logic        advance;
	logic        load_cmd;
	logic        emit_done;
	logic        emit_pend_mid;
	logic        emit_pend_last;
	logic [17:0] row_base;
	logic [15:0] addr;

	assign out_free = !out_v_q || pixel.ready;

	always_comb begin
		visible = ($signed(cur_x_q) >= $signed({8'b0, cfg.clip_left}))
		       && ($signed(cur_x_q) < $signed({7'b0, cfg.clip_right_excl}))
		       && ($signed(cur_y_q) >= $signed({8'b0, cfg.clip_top}))
		       && ($signed(cur_y_q) < $signed({7'b0, cfg.clip_bottom_excl}));
		// A visible row is below 512, so its low nine bits are the whole row.
		row_base = cur_y_q[8:0] * cfg.row_pitch;
		addr     = row_base[15:0] + {7'b0, cur_x_q[8:0]};
	end

	assign advance = !(visible && pend_v_q && !out_free);

	// Next walk state.
	always_comb begin
		walk_n = walk_q;
		unique case (walk_q)
			WALK_IDLE: begin
				if (!cmd_empty && !cmd_head.is_done) walk_n = WALK_RUN;
			end
			WALK_RUN: begin
				if (advance && left_q == 6'd1) walk_n = WALK_FLUSH;
			end
			WALK_FLUSH: begin
				if (!pend_v_q || out_free) walk_n = WALK_IDLE;
			end
			default: walk_n = WALK_IDLE;
		endcase
	end

	// Walk control outputs.
	always_comb begin
		load_cmd       = 1'b0;
		emit_done      = 1'b0;
		emit_pend_mid  = 1'b0;
		emit_pend_last = 1'b0;
		unique case (walk_q)
			WALK_IDLE: begin
				load_cmd  = !cmd_empty && !cmd_head.is_done;
				emit_done = !cmd_empty && cmd_head.is_done && out_free;
			end
			WALK_RUN: begin
				emit_pend_mid = advance && visible && pend_v_q;
			end
			WALK_FLUSH: begin
				emit_pend_last = pend_v_q && out_free;
			end
			default: load_cmd = 1'b0;
		endcase
	end

	assign cmd_pop = load_cmd || emit_done;

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cur_x_q <= cmd_head.x;
			cur_y_q <= cmd_head.y;
			val_q   <= cmd_head.value;
			flip_q  <= cmd_head.flip;
		end else if (walk_q == WALK_RUN && advance) begin
			cur_x_q <= step_x(cur_x_q, 16'd1, flip_q);
		end
		if (walk_q == WALK_RUN && advance && visible) begin
			pend_addr_q <= addr;
			pend_val_q  <= val_q;
		end
		if (emit_done) begin
			out_addr_q <= '0;
			out_val_q  <= '0;
			out_wv_q   <= 1'b0;
			out_done_q <= 1'b1;
			out_last_q <= 1'b1;
		end else if (emit_pend_mid || emit_pend_last) begin
			out_addr_q <= pend_addr_q;
			out_val_q  <= pend_val_q;
			out_wv_q   <= 1'b1;
			out_done_q <= 1'b0;
			out_last_q <= emit_pend_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q   <= WALK_IDLE;
			left_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			walk_q <= walk_n;
			if (load_cmd) begin
				left_q <= cmd_head.count;
			end else if (walk_q == WALK_RUN && advance) begin
				left_q <= left_q - 6'd1;
			end
			if (walk_q == WALK_RUN && advance && visible) begin
				pend_v_q <= 1'b1;
			end else if (emit_pend_last) begin
				pend_v_q <= 1'b0;
			end
			if (emit_done || emit_pend_mid || emit_pend_last) begin
				out_v_q <= 1'b1;
			end else if (pixel.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign pixel.valid         = out_v_q;
	assign pixel.pixel_address = out_addr_q;
	assign pixel.pixel_value   = out_val_q;
	assign pixel.write_valid   = out_wv_q;
	assign pixel.sprite_done   = out_done_q;
	assign pixel.last_of_run   = out_last_q;

endmodule

[rtl/core/clipped_rle_sprite_decoder_core.sv]
// ----------------------------------------------------------------------------
// clipped_rle_sprite_decoder_core
// Run-length sprite decoder with window clipping and horizontal mirroring.
// ----------------------------------------------------------------------------
// Usage:
// The sprite channel takes one stream byte per beat. A beat with sprite_start
// set opens a new sprite (abandoning any sprite in progress) and latches
// origin_x, origin_y and mirror; six header bytes, this one first, then code.
// The pixel channel gives one beat per visible pixel, in drawing order, with
// its frame buffer address, and one beat with sprite_done for the end code.
// last_of_run marks the final beat caused by one input byte.
// The front decoder takes one byte per cycle as long as its command queue
// has room. The back end walks each run at one pixel per cycle while the
// output takes its pixels, then closes the run in its flush state;
// meanwhile later bytes keep filling the queue, and the sprite
// channel only stalls once the queue is full.
// With the back end idle, a byte's first pixel passes the queue, the cursor
// and pending-pixel registers before the output; an end marker skips both.
// If the receiver stalls, the held output beat stays put, the walker stops
// at the next visible pixel, and back pressure reaches the input through
// the queue. Reset clears the decoder to waiting for a sprite start, empties
// the queue and loads the default clip window and pitch. The clip registers
// may only be written while no sprite is being drawn.
// ----------------------------------------------------------------------------
module clipped_rle_sprite_decoder_core import crsd_pkg::*; #(
	parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
	parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef,
	parameter int unsigned QUEUE_DEPTH   = QueueDepthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	crsd_in_if.sink             sprite,
	crsd_out_if.source          pixel
);

	// Reset window covers the screen, with each bound held to 256.
	localparam logic [8:0] RightRst  = (SCREEN_WIDTH > 256) ? 9'd256 : 9'(SCREEN_WIDTH);
	localparam logic [8:0] BottomRst = (SCREEN_HEIGHT > 256) ? 9'd256 : 9'(SCREEN_HEIGHT);

	clip_cfg_t cfg_q;
	logic      cmd_push;
	draw_cmd_t cmd_data;
	logic      cmd_full;
	logic      cmd_pop;
	logic      cmd_empty;
	draw_cmd_t cmd_head;

	// Configuration registers. Unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left        <= '0;
			cfg_q.clip_top         <= '0;
			cfg_q.clip_right_excl  <= RightRst;
			cfg_q.clip_bottom_excl <= BottomRst;
			cfg_q.row_pitch        <= RightRst;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CLIP_LEFT:        cfg_q.clip_left        <= cfg_data[7:0];
				CFG_CLIP_TOP:         cfg_q.clip_top         <= cfg_data[7:0];
				CFG_CLIP_RIGHT_EXCL:  cfg_q.clip_right_excl  <= cfg_data;
				CFG_CLIP_BOTTOM_EXCL: cfg_q.clip_bottom_excl <= cfg_data;
				CFG_ROW_PITCH:        cfg_q.row_pitch        <= cfg_data;
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Front: parses the byte stream and issues run commands.
	crsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sprite   (sprite),
		.cfg      (cfg_q),
		.cmd_push (cmd_push),
		.cmd_data (cmd_data),
		.cmd_full (cmd_full)
	);

	// Queue decoupling byte parsing from pixel generation.
	crsd_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_data),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.empty     (cmd_empty),
		.head      (cmd_head)
	);

	// Back: walks runs, clips pixels and drives the output register.
	crsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.pixel     (pixel)
	);

endmodule

[rtl/core/crsd_checker.sv]
// ----------------------------------------------------------------------------
// crsd_checker
// Port-level checks on the pixel channel of the sprite decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pixel_valid,
	input logic        pixel_ready,
	input logic [15:0] pixel_address,
	input logic [7:0]  pixel_value,
	input logic        write_valid,
	input logic        sprite_done,
	input logic        last_of_run
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, pixel_valid && !pixel_ready, pixel_valid)

	`ASSERT_NEXT(a_out_stable, clk, arst_n, pixel_valid && !pixel_ready, $stable(pixel_address) && $stable(pixel_value) && $stable(write_valid) && $stable(sprite_done) && $stable(last_of_run))

	// The end-of-sprite beat is a bare marker that closes its byte.
	`ASSERT_IMPLIES(a_done_beat, clk, arst_n, pixel_valid && sprite_done, !write_valid && last_of_run && pixel_address == 16'h0000 && pixel_value == 8'h00)

	// Every beat is either a pixel write or the end marker, never both.
	`ASSERT_IMPLIES(a_beat_kind, clk, arst_n, pixel_valid, write_valid != sprite_done)

endmodule

bind clipped_rle_sprite_decoder_core crsd_checker u_crsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pixel_valid   (pixel.valid),
	.pixel_ready   (pixel.ready),
	.pixel_address (pixel.pixel_address),
	.pixel_value   (pixel.pixel_value),
	.write_valid   (pixel.write_valid),
	.sprite_done   (pixel.sprite_done),
	.last_of_run   (pixel.last_of_run)
);
